/* rtl/dvnp_pkg.sv */
// Package for the dotted variable name parser: codes, reset values and shared types.
package dvnp_pkg;

  // Default width of the saturating number accumulator.
  localparam int unsigned NUM_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned NUMO_W  = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFGIX_W = 2;

  // Configuration register indexes and reset values.
  localparam logic [CFGIX_W-1:0] REG_MAX_ELEMENTS = 2'd0;
  localparam logic [CFGIX_W-1:0] REG_MAX_NAME_LEN = 2'd1;
  localparam logic [IDX_W-1:0]   MAX_ELEMENTS_RST = 4'd4;
  localparam logic [LEN_W-1:0]   MAX_NAME_LEN_RST = 8'd64;

  // Characters of interest.
  localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CH_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE       = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CH_W-1:0] CH_LOW_A      = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_Z      = 8'h7A;
  localparam logic [CH_W-1:0] CH_UP_A       = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z       = 8'h5A;

  // Element kinds.
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NUM   = 2'd2;

  // Outcome codes.
  localparam logic [STAT_W-1:0] ST_RUN = 2'd0;
  localparam logic [STAT_W-1:0] ST_OK  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_IDENT = 3'b010,
    PH_NUM   = 3'b100
  } phase_t;

  // Parse state apart from the number accumulator.
  typedef struct packed {
    phase_t             phase;
    logic [IDX_W-1:0]   elem_idx;
    logic [LEN_W-1:0]   cur_len;
    logic               skip_rest;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic               consumed;
    logic [IDX_W-1:0]   element_index;
    logic [KIND_W-1:0]  element_kind;
    logic [CH_W-1:0]    ident_char;
    logic [LEN_W-1:0]   ident_len;
    logic [NUMO_W-1:0]  num_value;
    logic               done_res;
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   element_count;
  } result_t;

endpackage

/* rtl/dvnp_step.sv */
// Per-character decision logic of the dotted variable name parser.
module dvnp_step #(
  parameter int unsigned NUM_BITS = dvnp_pkg::NUM_BITS_DEF
) (
  input  dvnp_pkg::parse_state_t            st,
  input  logic [NUM_BITS-1:0]               cur_num,
  input  logic [dvnp_pkg::CH_W-1:0]         ch,
  input  logic                              last,
  input  logic [dvnp_pkg::IDX_W-1:0]        max_elements,
  input  logic [dvnp_pkg::LEN_W-1:0]        max_name_len,
  output dvnp_pkg::parse_state_t            st_next,
  output logic [NUM_BITS-1:0]               cur_num_next,
  output dvnp_pkg::result_t                 res
);

  localparam logic [NUM_BITS-1:0] NMAX = {NUM_BITS{1'b1}};

  logic                              is_alpha;
  logic                              is_digit;
  logic                              is_ident;
  logic [3:0]                        digit;
  logic [NUM_BITS+3:0]               mac;
  logic [NUM_BITS-1:0]               num_sat;
  logic [NUM_BITS+dvnp_pkg::NUMO_W-1:0] num_wide;
  logic [dvnp_pkg::IDX_W:0]          count;
  logic [dvnp_pkg::LEN_W-1:0]        len_inc;
  logic                              fin;
  logic [dvnp_pkg::STAT_W-1:0]       fin_st;
  logic [dvnp_pkg::IDX_W-1:0]        fin_cnt;
  logic                              do_dot;

  assign is_alpha = ((ch >= dvnp_pkg::CH_LOW_A) && (ch <= dvnp_pkg::CH_LOW_Z)) ||
                    ((ch >= dvnp_pkg::CH_UP_A) && (ch <= dvnp_pkg::CH_UP_Z));
  assign is_digit = (ch >= dvnp_pkg::CH_ZERO) && (ch <= dvnp_pkg::CH_NINE);
  assign is_ident = is_alpha || is_digit || (ch == dvnp_pkg::CH_UNDERSCORE);
  assign digit    = ch[3:0];

  // Accumulator times ten plus the new digit, as two shifts and adds.
  assign mac = ({4'b0, cur_num} << 3) + ({4'b0, cur_num} << 1) +
               {{NUM_BITS{1'b0}}, digit};
  assign num_sat = (mac[NUM_BITS+3:NUM_BITS] != 4'b0) ? NMAX : mac[NUM_BITS-1:0];

  assign count   = {1'b0, st.elem_idx} + 1'b1;
  assign len_inc = st.cur_len + 1'b1;

  always_comb begin
    st_next      = st;
    cur_num_next = cur_num;
    res          = '0;
    fin          = 1'b0;
    fin_st       = dvnp_pkg::ST_RUN;
    fin_cnt      = count[dvnp_pkg::IDX_W-1:0];
    do_dot       = 1'b0;
    num_wide     = '0;

    if (st.skip_rest) begin
      // The rest of a finished string is swallowed with an all-zero result.
      if (last) begin
        st_next.phase     = dvnp_pkg::PH_START;
        st_next.elem_idx  = '0;
        st_next.cur_len   = '0;
        st_next.skip_rest = 1'b0;
        cur_num_next      = '0;
      end
    end else begin
      res.element_index = st.elem_idx;
      unique case (st.phase)
        dvnp_pkg::PH_START: begin
          if (st.elem_idx >= max_elements) begin
            fin    = 1'b1;
            fin_st = dvnp_pkg::ST_ERR;
          end else if (is_alpha || (ch == dvnp_pkg::CH_UNDERSCORE)) begin
            st_next.cur_len  = 8'd1;
            res.consumed     = 1'b1;
            res.element_kind = dvnp_pkg::KIND_IDENT;
            res.ident_char   = ch;
            res.ident_len    = 8'd1;
            if (last) begin
              fin    = 1'b1;
              fin_st = dvnp_pkg::ST_OK;
            end else begin
              st_next.phase = dvnp_pkg::PH_IDENT;
            end
          end else if (is_digit) begin
            cur_num_next     = {{(NUM_BITS-4){1'b0}}, digit};
            num_wide         = {{dvnp_pkg::NUMO_W{1'b0}}, cur_num_next};
            res.consumed     = 1'b1;
            res.element_kind = dvnp_pkg::KIND_NUM;
            res.num_value    = num_wide[dvnp_pkg::NUMO_W-1:0];
            if (last) begin
              fin    = 1'b1;
              fin_st = dvnp_pkg::ST_OK;
            end else begin
              st_next.phase = dvnp_pkg::PH_NUM;
            end
          end else begin
            fin    = 1'b1;
            fin_st = dvnp_pkg::ST_ERR;
          end
        end
        dvnp_pkg::PH_IDENT: begin
          if (is_ident) begin
            if (st.cur_len >= max_name_len) begin
              fin    = 1'b1;
              fin_st = dvnp_pkg::ST_ERR;
            end else begin
              st_next.cur_len  = len_inc;
              res.consumed     = 1'b1;
              res.element_kind = dvnp_pkg::KIND_IDENT;
              res.ident_char   = ch;
              res.ident_len    = len_inc;
              if (last) begin
                fin    = 1'b1;
                fin_st = dvnp_pkg::ST_OK;
              end
            end
          end else if (ch == dvnp_pkg::CH_DOT) begin
            do_dot = 1'b1;
          end else begin
            fin    = 1'b1;
            fin_st = dvnp_pkg::ST_OK;
          end
        end
        dvnp_pkg::PH_NUM: begin
          if (is_digit) begin
            cur_num_next     = num_sat;
            num_wide         = {{dvnp_pkg::NUMO_W{1'b0}}, num_sat};
            res.consumed     = 1'b1;
            res.element_kind = dvnp_pkg::KIND_NUM;
            res.num_value    = num_wide[dvnp_pkg::NUMO_W-1:0];
            if (last) begin
              fin    = 1'b1;
              fin_st = dvnp_pkg::ST_OK;
            end
          end else if (st.elem_idx == '0) begin
            // A leading number is a complete name of one element.
            fin    = 1'b1;
            fin_st = dvnp_pkg::ST_OK;
          end else if (ch == dvnp_pkg::CH_DOT) begin
            do_dot = 1'b1;
          end else begin
            fin    = 1'b1;
            fin_st = dvnp_pkg::ST_OK;
          end
        end
        default: begin
          fin    = 1'b1;
          fin_st = dvnp_pkg::ST_ERR;
        end
      endcase

      // A dot closes the element; it fails if it would open one too many
      // or if the string ends on it.
      if (do_dot) begin
        if ((count >= {1'b0, max_elements}) || last) begin
          fin    = 1'b1;
          fin_st = dvnp_pkg::ST_ERR;
        end else begin
          res.consumed     = 1'b1;
          st_next.elem_idx = count[dvnp_pkg::IDX_W-1:0];
          st_next.phase    = dvnp_pkg::PH_START;
          st_next.cur_len  = '0;
          cur_num_next     = '0;
        end
      end

      if (fin) begin
        res.done_res      = 1'b1;
        res.status        = fin_st;
        res.element_count = (fin_st == dvnp_pkg::ST_OK) ? fin_cnt : '0;
        if (last) begin
          st_next.phase     = dvnp_pkg::PH_START;
          st_next.elem_idx  = '0;
          st_next.cur_len   = '0;
          st_next.skip_rest = 1'b0;
          cur_num_next      = '0;
        end else begin
          st_next.skip_rest = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/dotted_variable_name_parser_core.sv */
// Top level of the dotted variable name parser: handshakes, registers and configuration.
//
// The block reads a string one character per item on the input channel
// (ch, last) and returns exactly one result item per character on the output
// channel. Both channels use valid and stall: an item moves at a rising edge
// where valid is high and stall is low.
// An accepted character is held in an input register. The decision logic
// evaluates it against the parse state, and the result is written to the
// output register once that register is free or is being emptied; the
// receiver takes it from there. One character is accepted per cycle as
// long as the receiver keeps taking results; throughput is one item per
// clock. When the receiver stalls, the output register holds its result
// and the input register holds the next character; once both are full the
// block raises in_stall until the receiver takes the pending result.
// Configuration registers (max_elements, max_name_len) are written through
// cfg_we, cfg_index and cfg_data and should only change while the block is
// idle. A synchronous reset empties both registers, returns the parser to
// the start of a fresh string and loads the configuration defaults.
module dotted_variable_name_parser_core #(
  parameter int unsigned NUM_BITS = dvnp_pkg::NUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [dvnp_pkg::CFGIX_W-1:0]      cfg_index,
  input  logic [dvnp_pkg::CFG_W-1:0]        cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dvnp_pkg::CH_W-1:0]         ch,
  input  logic                              last,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              consumed,
  output logic [dvnp_pkg::IDX_W-1:0]        element_index,
  output logic [dvnp_pkg::KIND_W-1:0]       element_kind,
  output logic [dvnp_pkg::CH_W-1:0]         ident_char,
  output logic [dvnp_pkg::LEN_W-1:0]        ident_len,
  output logic [dvnp_pkg::NUMO_W-1:0]       num_value,
  output logic                              done_res,
  output logic [dvnp_pkg::STAT_W-1:0]       status,
  output logic [dvnp_pkg::IDX_W-1:0]        element_count
);

  logic [dvnp_pkg::IDX_W-1:0] max_elements;
  logic [dvnp_pkg::LEN_W-1:0] max_name_len;

  // Input register.
  logic                       in_full;
  logic [dvnp_pkg::CH_W-1:0]  in_ch;
  logic                       in_last;

  // Parse state.
  dvnp_pkg::parse_state_t     st;
  dvnp_pkg::parse_state_t     st_next;
  logic [NUM_BITS-1:0]        cur_num;
  logic [NUM_BITS-1:0]        cur_num_next;

  // Output register.
  dvnp_pkg::result_t          res;
  dvnp_pkg::result_t          res_next;

  logic                       advance;
  logic                       take_in;

  // The held character moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements <= dvnp_pkg::MAX_ELEMENTS_RST;
      max_name_len <= dvnp_pkg::MAX_NAME_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvnp_pkg::REG_MAX_ELEMENTS: max_elements <= cfg_data[dvnp_pkg::IDX_W-1:0];
        dvnp_pkg::REG_MAX_NAME_LEN: max_name_len <= cfg_data[dvnp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_ch   <= ch;
      in_last <= last;
    end
  end

  dvnp_step #(
    .NUM_BITS(NUM_BITS)
  ) u_step (
    .st           (st),
    .cur_num      (cur_num),
    .ch           (in_ch),
    .last         (in_last),
    .max_elements (max_elements),
    .max_name_len (max_name_len),
    .st_next      (st_next),
    .cur_num_next (cur_num_next),
    .res          (res_next)
  );

  // Parse state advances once per character, together with its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= dvnp_pkg::PH_START;
      st.elem_idx  <= '0;
      st.cur_len   <= '0;
      st.skip_rest <= 1'b0;
      cur_num      <= '0;
    end else if (advance) begin
      st      <= st_next;
      cur_num <= cur_num_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign consumed      = res.consumed;
  assign element_index = res.element_index;
  assign element_kind  = res.element_kind;
  assign ident_char    = res.ident_char;
  assign ident_len     = res.ident_len;
  assign num_value     = res.num_value;
  assign done_res      = res.done_res;
  assign status        = res.status;
  assign element_count = res.element_count;

endmodule

/* sim/tb_dotted_variable_name_parser_core.sv */
// Testbench for the dotted variable name parser: directed strings, limit extremes, random names.
module tb_dotted_variable_name_parser_core;

  localparam int unsigned NUM_BITS = dvnp_pkg::NUM_BITS_DEF;

  // Clock and reset. Every input of the block starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  logic                          cfg_we    = 1'b0;
  logic [dvnp_pkg::CFGIX_W-1:0]  cfg_index = '0;
  logic [dvnp_pkg::CFG_W-1:0]    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic [dvnp_pkg::CH_W-1:0]     ch        = '0;
  logic                          last      = 1'b0;
  logic                          out_stall = 1'b0;

  logic                          in_stall;
  logic                          out_valid;
  logic                          consumed;
  logic [dvnp_pkg::IDX_W-1:0]    element_index;
  logic [dvnp_pkg::KIND_W-1:0]   element_kind;
  logic [dvnp_pkg::CH_W-1:0]     ident_char;
  logic [dvnp_pkg::LEN_W-1:0]    ident_len;
  logic [dvnp_pkg::NUMO_W-1:0]   num_value;
  logic                          done_res;
  logic [dvnp_pkg::STAT_W-1:0]   status;
  logic [dvnp_pkg::IDX_W-1:0]    element_count;

  dotted_variable_name_parser_core #(
    .NUM_BITS(NUM_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .consumed      (consumed),
    .element_index (element_index),
    .element_kind  (element_kind),
    .ident_char    (ident_char),
    .ident_len     (ident_len),
    .num_value     (num_value),
    .done_res      (done_res),
    .status        (status),
    .element_count (element_count)
  );

  // ---------------------------------------------------------------------
  // Parse tracker. This mirrors the parser state as it must be after every
  // accepted character, together with the two limits currently programmed.
  // ---------------------------------------------------------------------
  logic [dvnp_pkg::IDX_W-1:0] lim_elems = dvnp_pkg::MAX_ELEMENTS_RST;
  logic [dvnp_pkg::LEN_W-1:0] lim_len   = dvnp_pkg::MAX_NAME_LEN_RST;

  dvnp_pkg::phase_t           trk_phase = dvnp_pkg::PH_START;
  logic [dvnp_pkg::IDX_W-1:0] trk_elem  = '0;
  logic [dvnp_pkg::LEN_W-1:0] trk_len   = '0;
  logic [63:0]                trk_num   = '0;
  logic                       trk_skip  = 1'b0;

  // Expected results in the order their characters were accepted.
  dvnp_pkg::result_t expected_results[$];
  int                mismatch_count = 0;

  // Characters of the string that is about to be sent.
  logic [dvnp_pkg::CH_W-1:0] str_buf[$];

  function automatic void reset_parse();
    trk_phase = dvnp_pkg::PH_START;
    trk_elem  = '0;
    trk_len   = '0;
    trk_num   = '0;
    trk_skip  = 1'b0;
  endfunction

  function automatic bit is_letter(logic [dvnp_pkg::CH_W-1:0] c);
    return (c >= dvnp_pkg::CH_LOW_A && c <= dvnp_pkg::CH_LOW_Z) ||
           (c >= dvnp_pkg::CH_UP_A && c <= dvnp_pkg::CH_UP_Z);
  endfunction

  function automatic bit is_digit(logic [dvnp_pkg::CH_W-1:0] c);
    return c >= dvnp_pkg::CH_ZERO && c <= dvnp_pkg::CH_NINE;
  endfunction

  // The parse finishes on this character. When the string goes on, the
  // rest of it is ignored until its final character.
  function automatic dvnp_pkg::result_t close_parse(dvnp_pkg::result_t r,
                                                    logic [dvnp_pkg::STAT_W-1:0] st,
                                                    logic [4:0] cnt, logic l);
    r.done_res      = 1'b1;
    r.status        = st;
    r.element_count = (st == dvnp_pkg::ST_OK) ? cnt[3:0] : '0;
    if (l) reset_parse();
    else trk_skip = 1'b1;
    return r;
  endfunction

  // A dot closes the current element and opens the next one, unless that
  // would pass the element limit or the string ends on the dot.
  function automatic dvnp_pkg::result_t close_element(dvnp_pkg::result_t r, logic l);
    logic [4:0] cnt;
    cnt = {1'b0, trk_elem} + 5'd1;
    if (cnt >= {1'b0, lim_elems} || l) return close_parse(r, dvnp_pkg::ST_ERR, 5'd0, l);
    r.consumed = 1'b1;
    trk_elem   = cnt[3:0];
    trk_phase  = dvnp_pkg::PH_START;
    trk_len    = '0;
    trk_num    = '0;
    return r;
  endfunction

  // Works out the result of one character and advances the tracked state.
  function automatic dvnp_pkg::result_t parse_char(logic [dvnp_pkg::CH_W-1:0] c, logic l);
    dvnp_pkg::result_t r;
    logic [63:0]       nmax;
    logic [63:0]       v;
    logic [4:0]        cnt;
    nmax = (64'd1 << NUM_BITS) - 64'd1;
    r    = '0;
    if (trk_skip) begin
      if (l) reset_parse();
      return r;
    end
    r.element_index = trk_elem;
    cnt = {1'b0, trk_elem} + 5'd1;
    case (trk_phase)
      dvnp_pkg::PH_START: begin
        if (trk_elem >= lim_elems) begin
          r = close_parse(r, dvnp_pkg::ST_ERR, 5'd0, l);
        end else if (is_letter(c) || c == dvnp_pkg::CH_UNDERSCORE) begin
          trk_len        = 8'd1;
          r.consumed     = 1'b1;
          r.element_kind = dvnp_pkg::KIND_IDENT;
          r.ident_char   = c;
          r.ident_len    = trk_len;
          if (l) r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
          else trk_phase = dvnp_pkg::PH_IDENT;
        end else if (is_digit(c)) begin
          trk_num = 64'(c - dvnp_pkg::CH_ZERO);
          if (trk_num > nmax) trk_num = nmax;
          r.consumed     = 1'b1;
          r.element_kind = dvnp_pkg::KIND_NUM;
          r.num_value    = trk_num[15:0];
          if (l) r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
          else trk_phase = dvnp_pkg::PH_NUM;
        end else begin
          r = close_parse(r, dvnp_pkg::ST_ERR, 5'd0, l);
        end
      end
      dvnp_pkg::PH_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == dvnp_pkg::CH_UNDERSCORE) begin
          if (trk_len >= lim_len) begin
            r = close_parse(r, dvnp_pkg::ST_ERR, 5'd0, l);
          end else begin
            trk_len        = trk_len + 8'd1;
            r.consumed     = 1'b1;
            r.element_kind = dvnp_pkg::KIND_IDENT;
            r.ident_char   = c;
            r.ident_len    = trk_len;
            if (l) r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
          end
        end else if (c == dvnp_pkg::CH_DOT) begin
          r = close_element(r, l);
        end else begin
          r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
        end
      end
      default: begin
        if (is_digit(c)) begin
          v = trk_num * 64'd10 + 64'(c - dvnp_pkg::CH_ZERO);
          trk_num        = (v > nmax) ? nmax : v;
          r.consumed     = 1'b1;
          r.element_kind = dvnp_pkg::KIND_NUM;
          r.num_value    = trk_num[15:0];
          if (l) r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
        end else if (trk_elem == '0) begin
          // A leading number ends the name at its first non-digit.
          r = close_parse(r, dvnp_pkg::ST_OK, 5'd1, l);
        end else if (c == dvnp_pkg::CH_DOT) begin
          r = close_element(r, l);
        end else begin
          r = close_parse(r, dvnp_pkg::ST_OK, cnt, l);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Items go out in bursts of random length with random gaps in
  // between; now and then a long burst gives a stretch with no idling.
  // Every task below is entered and left right after a rising edge.
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(logic [dvnp_pkg::CH_W-1:0] c, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 120))
                                                : int'($urandom_range(1, 20));
    end
    burst_left--;
    in_valid <= 1'b1;
    ch       <= c;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(parse_char(c, l));
  endtask

  // Sends the buffered string; the final character carries last when asked.
  task automatic send_string(bit mark_last);
    for (int i = 0; i < str_buf.size(); i++)
      send_item(str_buf[i], mark_last && (i == str_buf.size() - 1));
    str_buf.delete();
  endtask

  // Holds the sender back until every expected result has come out, then
  // lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dvnp_pkg::CFGIX_W-1:0] idx,
                           logic [dvnp_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == dvnp_pkg::REG_MAX_ELEMENTS) lim_elems = val[dvnp_pkg::IDX_W-1:0];
    else if (idx == dvnp_pkg::REG_MAX_NAME_LEN) lim_len = val;
  endtask

  // Limits change only with the block idle.
  task automatic set_limits(logic [dvnp_pkg::IDX_W-1:0] elems,
                            logic [dvnp_pkg::LEN_W-1:0] len);
    drain();
    write_reg(dvnp_pkg::REG_MAX_ELEMENTS, dvnp_pkg::CFG_W'(elems));
    write_reg(dvnp_pkg::REG_MAX_NAME_LEN, len);
    cfg_we <= 1'b0;
  endtask

  function automatic void put_byte(logic [dvnp_pkg::CH_W-1:0] b);
    str_buf.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(dvnp_pkg::CH_W'(s[i]));
  endfunction

  function automatic logic [dvnp_pkg::CH_W-1:0] pick_ident_char(bit first);
    int k;
    k = int'($urandom_range(0, first ? 52 : 62));
    if (k < 26) return dvnp_pkg::CH_LOW_A + dvnp_pkg::CH_W'(k);
    if (k < 52) return dvnp_pkg::CH_UP_A + dvnp_pkg::CH_W'(k - 26);
    if (k == 52) return dvnp_pkg::CH_UNDERSCORE;
    return dvnp_pkg::CH_ZERO + dvnp_pkg::CH_W'(k - 53);
  endfunction

  // Mostly short identifiers; sometimes one just under, right at or one past
  // the length limit.
  function automatic int pick_ident_len();
    int n;
    bit near;
    near = (lim_len <= 8'd16) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 59) == 0);
    if (!near) return int'($urandom_range(1, 6));
    n = int'(lim_len) - 1 + int'($urandom_range(0, 2));
    return (n < 1) ? 1 : n;
  endfunction

  // Builds one random string. Most are well-formed dotted names with random
  // content and a random ending; some get one byte overwritten, and a few
  // are plain noise.
  function automatic void build_random_string();
    int sel;
    int n_elem;
    int n;
    int tail;
    int pos;
    sel = int'($urandom_range(0, 99));
    if (sel < 10) begin
      repeat ($urandom_range(1, 5)) put_byte(dvnp_pkg::CH_W'($urandom_range(0, 255)));
      return;
    end
    n_elem = int'($urandom_range(1, int'(lim_elems) + 1));
    for (int i = 0; i < n_elem; i++) begin
      if (i > 0) put_byte(dvnp_pkg::CH_DOT);
      if ($urandom_range(0, 99) < ((i == 0) ? 15 : 35)) begin
        n = int'($urandom_range(1, 6));
        repeat (n) put_byte(dvnp_pkg::CH_ZERO + dvnp_pkg::CH_W'($urandom_range(0, 9)));
      end else begin
        n = pick_ident_len();
        put_byte(pick_ident_char(1'b1));
        for (int j = 1; j < n; j++) put_byte(pick_ident_char(1'b0));
      end
    end
    tail = int'($urandom_range(0, 9));
    if (tail >= 5 && tail <= 6) begin
      put_byte(dvnp_pkg::CH_DOT);
    end else if (tail >= 7) begin
      put_byte(dvnp_pkg::CH_W'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) put_byte(dvnp_pkg::CH_W'($urandom_range(0, 255)));
    end
    if (sel < 25) begin
      pos = int'($urandom_range(0, str_buf.size() - 1));
      str_buf[pos] = dvnp_pkg::CH_W'($urandom_range(0, 255));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver. The stall pattern switches between modes of random length:
  // no stall, light random stall, occasional long holds, heavy stall.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = int'($urandom_range(0, 3));
      mode_left  = int'($urandom_range(20, 150));
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: begin
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          hold_left = int'($urandom_range(1, 8));
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // ---------------------------------------------------------------------
  // Result checker. Each result taken is compared field by field with the
  // oldest expectation.
  // ---------------------------------------------------------------------
  dvnp_pkg::result_t want;

  task automatic compare_field(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result taken with no character pending", $time);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("consumed", 16'(want.consumed), 16'(consumed));
        compare_field("element_index", 16'(want.element_index), 16'(element_index));
        compare_field("element_kind", 16'(want.element_kind), 16'(element_kind));
        compare_field("ident_char", 16'(want.ident_char), 16'(ident_char));
        compare_field("ident_len", 16'(want.ident_len), 16'(ident_len));
        compare_field("num_value", want.num_value, num_value);
        compare_field("done_res", 16'(want.done_res), 16'(done_res));
        compare_field("status", 16'(want.status), 16'(status));
        compare_field("element_count", 16'(want.element_count), 16'(element_count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Reset limits: identifier and number elements, character class edges.
  task automatic test_directed_defaults();
    // Identifier with every class of character, then a trailing dot.
    put_text("_Az9.");
    send_string(1'b1);
    // Leading number that saturates; the dot after it ends the name.
    put_text("99999.");
    send_string(1'b1);
    // Number in a later element ended by a zero byte.
    put_text("a.0");
    put_byte(8'h00);
    send_string(1'b1);
    // All-ones byte can not start a name.
    put_byte(8'hFF);
    send_string(1'b1);
    // Empty element between two dots; the character after it is ignored.
    put_text("a..z");
    send_string(1'b1);
  endtask

  // Smallest limits: one element, one character per identifier.
  task automatic test_limit_extremes();
    set_limits(4'd1, 8'd1);
    // The dot would open a second element.
    put_text("a.b");
    send_string(1'b1);
    // Second identifier character goes past the length limit.
    put_text("ab");
    send_string(1'b1);
    // Lower the element limit in the middle of a string: the next element
    // start then sits at an index the limit no longer allows.
    set_limits(4'd2, 8'd1);
    put_text("q.");
    send_string(1'b0);
    set_limits(4'd1, 8'd1);
    put_text("rs");
    send_string(1'b1);
  endtask

  // Random names under a series of limit settings, reset defaults first, then
  // extremes. The sender waits for every result at the end of each setting.
  task automatic test_random_names();
    int sent;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_limits(dvnp_pkg::MAX_ELEMENTS_RST, dvnp_pkg::MAX_NAME_LEN_RST);
        1: set_limits(4'd1, 8'd1);
        2: set_limits(4'd15, 8'd255);
        3: set_limits(4'd2, 8'd3);
        4: set_limits(4'd15, 8'd1);
        5: set_limits(4'd1, 8'd255);
        default: set_limits(dvnp_pkg::IDX_W'($urandom_range(1, 15)),
                            dvnp_pkg::LEN_W'($urandom_range(1, 255)));
      endcase
      sent = 0;
      while (sent < 145) begin
        build_random_string();
        sent += str_buf.size();
        send_string(1'b1);
      end
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_limit_extremes();
    test_random_names();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
